// ----- src/pool_linked_list_table_defines.svh -----
// Assertion macros shared by the pool linked list table modules.
`ifndef POOL_LINKED_LIST_TABLE_DEFINES_SVH
`define POOL_LINKED_LIST_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property at every clock edge outside reset.
`define PLLT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pllt assertion failed");

// Checks a condition on the edge right after a reset cycle.
`define PLLT_ASSERT_RESET(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) !rst_n |=> expr) \
        else $error("pllt reset assertion failed");

`else

`define PLLT_ASSERT(name, clk, rst_n, prop)
`define PLLT_ASSERT_RESET(name, clk, rst_n, expr)

`endif

`endif

// ----- src/pllt_pkg.sv -----
// Shared types, codes and helpers of the pool linked list table.
`default_nettype none

package pllt_pkg;

    localparam int POOL_SLOTS = 128;
    localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CMD_W      = 3;
    localparam int ID_W       = 16;
    localparam int TAG_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 7;

    typedef logic [SLOT_W-1:0] t_slot_idx;

    typedef struct packed {
        logic      valid;
        t_slot_idx next;
    } t_link;

    typedef enum logic [CMD_W-1:0] {
        CMD_REINIT  = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_REPLACE = 3'd3,
        CMD_FIND    = 3'd4,
        CMD_FETCH   = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_NO_HANDLER = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_FREE,
        RD_HEAD,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP_TAKE,
        S_APP_LINK,
        S_WALK,
        S_DEL_PREV,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    reinit;
        t_rd_sel rd_sel;
        logic    app_take;
        logic    app_link;
        logic    wr_handler;
        logic    del_unlink;
        logic    del_prev;
        logic    res_load;
        t_status res_status;
        logic    res_slot;
        logic    res_hout;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_v;
        logic free_v;
        logic hit;
        logic link_v;
        logic handler_nz;
        logic has_prev;
        logic out_free;
    } t_dp_stat;

    // Link of a slot that has not been written since the last pool reset.
    function automatic t_link link_reset_value(t_slot_idx idx);
        logic [SLOT_W:0] nxt;
        t_link           lnk;
        nxt       = {1'b0, idx} + (SLOT_W+1)'(1);
        lnk.valid = (nxt < (SLOT_W+1)'(POOL_SLOTS));
        lnk.next  = lnk.valid ? nxt[SLOT_W-1:0] : '0;
        return lnk;
    endfunction

endpackage

`default_nettype wire

// ----- src/pllt_dp.sv -----
// Datapath: slot memories, list pointers, list walk registers and result register.
`default_nettype none
`include "pool_linked_list_table_defines.svh"

module pllt_dp
    import pllt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd_bus,
    output t_dp_stat                   o_stat,
    input  wire logic [ID_W-1:0]       i_entry_id,
    input  wire logic [TAG_W-1:0]      i_handler_tag,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SLOT_OUT_W-1:0]      o_slot,
    output logic [TAG_W-1:0]           o_handler_out
);

    t_link              link_mem [POOL_SLOTS];
    logic [ID_W-1:0]    id_mem   [POOL_SLOTS];
    logic [TAG_W-1:0]   hdl_mem  [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] r_written;

    t_slot_idx          r_head, r_tail, r_free, r_cur, r_prev;
    logic               r_head_v, r_free_v, r_has_prev;
    logic [ID_W-1:0]    r_id;
    logic [TAG_W-1:0]   r_tag;
    t_link              r_rd_link, r_save;
    logic               r_rd_written;
    logic [ID_W-1:0]    r_rd_id;
    logic [TAG_W-1:0]   r_rd_hdl;
    logic               r_out_valid;
    logic [STATUS_W-1:0]   r_res_status;
    logic [SLOT_OUT_W-1:0] r_res_slot;
    logic [TAG_W-1:0]      r_res_hout;

    t_link     rd_link;
    t_slot_idx rd_addr;
    logic      rd_en;
    logic      lnk_we;
    t_slot_idx lnk_wa;
    t_link     lnk_wd;

    // Slots not written since the last pool reset read as the initial free chain.
    assign rd_link = r_rd_written ? r_rd_link : link_reset_value(r_cur);
    assign rd_en   = (i_cmd_bus.rd_sel != RD_NONE);

    always_comb begin
        case (i_cmd_bus.rd_sel)
            RD_FREE: rd_addr = r_free;
            RD_HEAD: rd_addr = r_head;
            RD_NEXT: rd_addr = rd_link.next;
            default: rd_addr = r_cur;
        endcase
    end

    always_comb begin
        lnk_we = 1'b1;
        lnk_wa = r_cur;
        lnk_wd = '0;
        if (i_cmd_bus.app_take) begin
            lnk_wa = r_cur;
            lnk_wd = '0;
        end else if (i_cmd_bus.app_link) begin
            lnk_wa = r_tail;
            lnk_wd = '{valid: 1'b1, next: r_cur};
        end else if (i_cmd_bus.del_unlink) begin
            lnk_wa = r_cur;
            lnk_wd = '{valid: r_free_v, next: r_free};
        end else if (i_cmd_bus.del_prev) begin
            lnk_wa = r_prev;
            lnk_wd = r_save;
        end else begin
            lnk_we = 1'b0;
        end
    end

    // Slot memories.
    always_ff @(posedge i_clk) begin
        if (lnk_we) begin
            link_mem[lnk_wa] <= lnk_wd;
        end
        if (i_cmd_bus.app_take) begin
            id_mem[r_cur] <= r_id;
        end
        if (i_cmd_bus.app_take || i_cmd_bus.wr_handler) begin
            hdl_mem[r_cur] <= r_tag;
        end
        if (rd_en) begin
            r_rd_link    <= link_mem[rd_addr];
            r_rd_id      <= id_mem[rd_addr];
            r_rd_hdl     <= hdl_mem[rd_addr];
            r_rd_written <= r_written[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_cmd_bus.reinit) begin
            r_written <= '0;
        end else if (lnk_we) begin
            r_written[lnk_wa] <= 1'b1;
        end
    end

    // List and free list pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v    <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_free_v    <= 1'b1;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd_bus.reinit) begin
                r_head_v <= 1'b0;
                r_free_v <= 1'b1;
                r_free   <= '0;
            end else if (i_cmd_bus.app_take) begin
                r_free   <= rd_link.next;
                r_free_v <= rd_link.valid;
                if (!r_head_v) begin
                    r_head   <= r_cur;
                    r_head_v <= 1'b1;
                    r_tail   <= r_cur;
                end
            end else if (i_cmd_bus.app_link) begin
                r_tail <= r_cur;
            end else if (i_cmd_bus.del_unlink) begin
                r_free   <= r_cur;
                r_free_v <= 1'b1;
                if (!r_has_prev) begin
                    r_head   <= rd_link.next;
                    r_head_v <= rd_link.valid;
                end else if (!rd_link.valid) begin
                    r_tail <= r_prev;
                end
            end

            if (i_cmd_bus.res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item, walk and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.capture) begin
            r_id  <= i_entry_id;
            r_tag <= i_handler_tag;
        end
        if (rd_en) begin
            r_cur <= rd_addr;
        end
        if (i_cmd_bus.rd_sel == RD_HEAD) begin
            r_has_prev <= 1'b0;
        end else if (i_cmd_bus.rd_sel == RD_NEXT) begin
            r_prev     <= r_cur;
            r_has_prev <= 1'b1;
        end
        if (i_cmd_bus.del_unlink) begin
            r_save <= rd_link;
        end
        if (i_cmd_bus.res_load) begin
            r_res_status <= i_cmd_bus.res_status;
            r_res_slot   <= i_cmd_bus.res_slot ? SLOT_OUT_W'(r_cur) : '0;
            r_res_hout   <= i_cmd_bus.res_hout ? r_rd_hdl : '0;
        end
    end

    assign o_stat.head_v     = r_head_v;
    assign o_stat.free_v     = r_free_v;
    assign o_stat.hit        = (r_rd_id == r_id);
    assign o_stat.link_v     = rd_link.valid;
    assign o_stat.handler_nz = (r_rd_hdl != '0);
    assign o_stat.has_prev   = r_has_prev;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_res_status;
    assign o_slot        = r_res_slot;
    assign o_handler_out = r_res_hout;

    `PLLT_ASSERT(a_reinit_empties, i_clk, i_rst_n, i_cmd_bus.reinit |=> (!r_head_v && r_free_v && r_free == '0))
    `PLLT_ASSERT(a_delete_frees, i_clk, i_rst_n, i_cmd_bus.del_unlink |=> (r_free_v && r_free == $past(r_cur)))
    `PLLT_ASSERT(a_load_needs_room, i_clk, i_rst_n, i_cmd_bus.res_load |-> (!r_out_valid || !i_out_stall))
    `PLLT_ASSERT_RESET(a_reset_state, i_clk, i_rst_n, (!r_out_valid && !r_head_v && r_free_v))

endmodule

`default_nettype wire

// ----- src/pllt_ctrl.sv -----
// Controller state machine that sequences each command over the datapath.
`default_nettype none
`include "pool_linked_list_table_defines.svh"

module pllt_ctrl
    import pllt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [CMD_W-1:0] i_cmd,
    output logic                  o_in_stall,
    input  wire t_dp_stat         i_stat,
    output t_dp_cmd               o_cmd_bus
);

    t_state            r_state, n_state;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    t_status           r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmd    <= CMD_REINIT;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state              = r_state;
        n_cmd                = r_cmd;
        n_status             = r_status;
        o_cmd_bus            = '0;
        o_cmd_bus.rd_sel     = RD_NONE;
        o_cmd_bus.res_status = r_status;
        o_in_stall           = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd_bus.capture = 1'b1;
                    n_cmd             = i_cmd;
                    n_state           = S_DONE;
                    n_status          = ST_NOT_FOUND;
                    unique case (i_cmd)
                        CMD_REINIT: begin
                            o_cmd_bus.reinit = 1'b1;
                            n_status         = ST_OK;
                        end
                        CMD_APPEND: begin
                            if (i_stat.free_v) begin
                                o_cmd_bus.rd_sel = RD_FREE;
                                n_state          = S_APP_TAKE;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        CMD_DELETE, CMD_REPLACE, CMD_FIND, CMD_FETCH: begin
                            if (i_stat.head_v) begin
                                o_cmd_bus.rd_sel = RD_HEAD;
                                n_state          = S_WALK;
                            end
                        end
                        default: begin
                            n_status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_APP_TAKE: begin
                o_cmd_bus.app_take = 1'b1;
                n_status           = ST_OK;
                n_state            = i_stat.head_v ? S_APP_LINK : S_DONE;
            end

            S_APP_LINK: begin
                o_cmd_bus.app_link = 1'b1;
                n_state            = S_DONE;
            end

            // One list slot is compared per cycle; the next read is issued from the link.
            S_WALK: begin
                if (i_stat.hit) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    case (r_cmd)
                        CMD_DELETE: begin
                            o_cmd_bus.del_unlink = 1'b1;
                            if (i_stat.has_prev) begin
                                n_state = S_DEL_PREV;
                            end
                        end
                        CMD_REPLACE: begin
                            o_cmd_bus.wr_handler = 1'b1;
                        end
                        CMD_FETCH: begin
                            if (!i_stat.handler_nz) begin
                                n_status = ST_NO_HANDLER;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end else if (i_stat.link_v) begin
                    o_cmd_bus.rd_sel = RD_NEXT;
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end

            S_DEL_PREV: begin
                o_cmd_bus.del_prev = 1'b1;
                n_state            = S_DONE;
            end

            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd_bus.res_load = 1'b1;
                    o_cmd_bus.res_slot = (r_status == ST_OK) && (r_cmd != CMD_REINIT);
                    o_cmd_bus.res_hout = (r_status == ST_OK) && (r_cmd == CMD_FETCH);
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PLLT_ASSERT(a_walk_continues, i_clk, i_rst_n, (r_state == S_WALK && !i_stat.hit && i_stat.link_v) |=> (r_state == S_WALK))
    `PLLT_ASSERT(a_reinit_one_step, i_clk, i_rst_n, (r_state == S_IDLE && i_in_valid && i_cmd == CMD_REINIT) |=> (r_state == S_DONE && r_status == ST_OK))
    `PLLT_ASSERT(a_load_only_done, i_clk, i_rst_n, o_cmd_bus.res_load |-> (r_state == S_DONE))
    `PLLT_ASSERT_RESET(a_reset_idle, i_clk, i_rst_n, (r_state == S_IDLE))

endmodule

`default_nettype wire

// ----- src/pool_linked_list_table.sv -----
// Reinit, no-op codes and failures found at once go straight to the result; append
// takes a free slot and, on a non-empty list, links it behind the tail; a search reads
// list slots one per cycle (one memory read port), and a delete of a non-head entry
// adds a step that relinks its predecessor. One item is in work at a time; the next is
// taken once its result sits in the output register. Reset, synchronous and active low,
// leaves an empty list with all slots on the free chain, as after a reinit command.
`default_nettype none

module pool_linked_list_table
    import pllt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [ID_W-1:0]       i_entry_id,
    input  wire logic [TAG_W-1:0]      i_handler_tag,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SLOT_OUT_W-1:0]      o_slot,
    output logic [TAG_W-1:0]           o_handler_out
);

    t_dp_cmd  cmd_bus;
    t_dp_stat dp_stat;

    pllt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd_bus  (cmd_bus)
    );

    pllt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_bus     (cmd_bus),
        .o_stat        (dp_stat),
        .i_entry_id    (i_entry_id),
        .i_handler_tag (i_handler_tag),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_handler_out (o_handler_out)
    );

endmodule

`default_nettype wire

// ----- bench/pool_linked_list_table_tb.sv -----
// Self-checking testbench of the pool linked list table against a predicting registry tracker.
module pool_linked_list_table_tb;
    import pllt_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 150;
    localparam int ITEMS_PER_PHASE = 390;

    // Tracks the list and the free chain and holds the answers still due from the block.
    class registry_tracker;
        typedef struct packed {
            t_status                status;
            logic [SLOT_OUT_W-1:0]  slot;
            logic [TAG_W-1:0]       hout;
        } t_answer;

        t_slot_idx        link_to  [POOL_SLOTS];
        bit               link_ok  [POOL_SLOTS];
        logic [ID_W-1:0]  slot_key [POOL_SLOTS];
        logic [TAG_W-1:0] slot_tag [POOL_SLOTS];
        t_slot_idx        head;
        bit               head_ok;
        t_slot_idx        free_top;
        bit               free_ok;
        t_answer          answers_due[$];
        int unsigned      fail_count;

        function new();
            fail_count = 0;
            clear_pool();
        endfunction

        function void clear_pool();
            for (int i = 0; i < POOL_SLOTS; i++) begin
                link_ok[i]  = (i + 1 < POOL_SLOTS);
                link_to[i]  = link_ok[i] ? t_slot_idx'(i + 1) : '0;
                slot_key[i] = '0;
                slot_tag[i] = '0;
            end
            head     = '0;
            head_ok  = 1'b0;
            free_top = '0;
            free_ok  = 1'b1;
        endfunction

        // First slot on the list that holds key; prev is its predecessor when has_prev is set.
        function bit find_key(input logic [ID_W-1:0] key, output t_slot_idx pos,
                              output t_slot_idx prev, output bit has_prev);
            t_slot_idx cur;
            bit        cur_ok;
            cur      = head;
            cur_ok   = head_ok;
            pos      = '0;
            prev     = '0;
            has_prev = 1'b0;
            for (int steps = 0; cur_ok && steps < POOL_SLOTS; steps++) begin
                if (slot_key[cur] == key) begin
                    pos = cur;
                    return 1'b1;
                end
                prev     = cur;
                has_prev = 1'b1;
                cur_ok   = link_ok[cur];
                cur      = link_to[cur];
            end
            return 1'b0;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] key,
                                   logic [TAG_W-1:0] tag);
            t_answer   ans;
            t_slot_idx pos;
            t_slot_idx prev;
            t_slot_idx cur;
            bit        has_prev;
            ans.status = ST_NOT_FOUND;
            ans.slot   = '0;
            ans.hout   = '0;
            case (cmd)
                CMD_REINIT: begin
                    clear_pool();
                    ans.status = ST_OK;
                end
                CMD_APPEND: begin
                    if (!free_ok) begin
                        ans.status = ST_FULL;
                    end else begin
                        pos           = free_top;
                        free_ok       = link_ok[pos];
                        free_top      = link_to[pos];
                        slot_key[pos] = key;
                        slot_tag[pos] = tag;
                        link_ok[pos]  = 1'b0;
                        link_to[pos]  = '0;
                        if (!head_ok) begin
                            head    = pos;
                            head_ok = 1'b1;
                        end else begin
                            cur = head;
                            for (int steps = 0; link_ok[cur] && steps < POOL_SLOTS; steps++)
                                cur = link_to[cur];
                            link_to[cur] = pos;
                            link_ok[cur] = 1'b1;
                        end
                        ans.status = ST_OK;
                        ans.slot   = SLOT_OUT_W'(pos);
                    end
                end
                CMD_DELETE: begin
                    if (find_key(key, pos, prev, has_prev)) begin
                        if (has_prev) begin
                            link_to[prev] = link_to[pos];
                            link_ok[prev] = link_ok[pos];
                        end else begin
                            head    = link_to[pos];
                            head_ok = link_ok[pos];
                        end
                        // The freed slot goes on top of the free chain.
                        link_to[pos] = free_top;
                        link_ok[pos] = free_ok;
                        free_top     = pos;
                        free_ok      = 1'b1;
                        ans.status   = ST_OK;
                        ans.slot     = SLOT_OUT_W'(pos);
                    end
                end
                CMD_REPLACE: begin
                    if (find_key(key, pos, prev, has_prev)) begin
                        slot_tag[pos] = tag;
                        ans.status    = ST_OK;
                        ans.slot      = SLOT_OUT_W'(pos);
                    end
                end
                CMD_FIND: begin
                    if (find_key(key, pos, prev, has_prev)) begin
                        ans.status = ST_OK;
                        ans.slot   = SLOT_OUT_W'(pos);
                    end
                end
                CMD_FETCH: begin
                    if (find_key(key, pos, prev, has_prev)) begin
                        if (slot_tag[pos] != '0) begin
                            ans.status = ST_OK;
                            ans.slot   = SLOT_OUT_W'(pos);
                            ans.hout   = slot_tag[pos];
                        end else begin
                            ans.status = ST_NO_HANDLER;
                        end
                    end
                end
                default: ;
            endcase
            answers_due.push_back(ans);
        endfunction

        task report_mismatch(string what);
            fail_count++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_answer(logic [STATUS_W-1:0] status, logic [SLOT_OUT_W-1:0] slot,
                          logic [TAG_W-1:0] hout);
            t_answer ans;
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("result with none due: status %0d slot %0d handler %h",
                                          status, slot, hout));
                return;
            end
            ans = answers_due.pop_front();
            if (status !== ans.status || slot !== ans.slot || hout !== ans.hout)
                report_mismatch($sformatf("status %0d/%0d slot %0d/%0d handler %h/%h (got/exp)",
                                          status, ans.status, slot, ans.slot, hout, ans.hout));
        endtask

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd;
    logic [ID_W-1:0]       i_entry_id;
    logic [TAG_W-1:0]      i_handler_tag;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic [TAG_W-1:0]      o_handler_out;

    registry_tracker registry;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    bit              hold_req;
    logic [ID_W-1:0] key_base;
    int unsigned     cycle_count = 0;

    pool_linked_list_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_entry_id    (i_entry_id),
        .i_handler_tag (i_handler_tag),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_handler_out (o_handler_out)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            registry.check_answer(o_status, o_slot, o_handler_out);
    end

    // Receiver side: random stalls, or one long hold-off when requested.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_stall = (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] key,
                         input logic [TAG_W-1:0] tag);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_cmd         = cmd;
        i_entry_id    = key;
        i_handler_tag = tag;
        do @(posedge i_clk); while (o_in_stall);
        registry.note_command(cmd, key, tag);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (registry.pending() != 0) @(negedge i_clk);
    endtask

    // Keys mostly share their upper bits so that searches hit and duplicates occur.
    function automatic logic [ID_W-1:0] pick_key();
        if ($urandom_range(99) < 80)
            return {key_base[ID_W-1:3], 3'($urandom_range(7))};
        return ID_W'($urandom);
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return '0;
        if (roll < 28)
            return '1;
        return TAG_W'($urandom);
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return CMD_APPEND;
        if (roll < 50)
            return CMD_DELETE;
        if (roll < 62)
            return CMD_REPLACE;
        if (roll < 80)
            return CMD_FIND;
        if (roll < 98)
            return CMD_FETCH;
        return CMD_REINIT;
    endfunction

    // Start from an empty pool and append until a few appends find it full.
    task automatic fill_pool(output int unsigned count);
        key_base = ID_W'($urandom);
        offer(CMD_REINIT, ID_W'($urandom), TAG_W'($urandom));
        count = POOL_SLOTS + $urandom_range(1, 4);
        repeat (count) offer(CMD_APPEND, pick_key(), pick_tag());
        count++;
    endtask

    task automatic run_directed();
        offer(CMD_FIND,    16'h0000, 16'h0000);
        offer(CMD_FETCH,   16'hFFFF, 16'h0000);
        offer(CMD_DELETE,  16'h0000, 16'hFFFF);
        offer(CMD_REPLACE, 16'hFFFF, 16'hFFFF);
        offer(CMD_APPEND,  16'h0000, 16'h0000);
        offer(CMD_APPEND,  16'hFFFF, 16'hFFFF);
        offer(CMD_APPEND,  16'h1234, 16'hA5A5);
        offer(CMD_APPEND,  16'hFFFF, 16'h5A5A);
        offer(CMD_FETCH,   16'h0000, 16'h0000);
        offer(CMD_FETCH,   16'hFFFF, 16'h0000);
        offer(CMD_REPLACE, 16'h0000, 16'h8001);
        offer(CMD_FETCH,   16'h0000, 16'h0000);
        offer(CMD_FIND,    16'h1234, 16'h0000);
        // The first of two equal keys goes away, then the second one is found.
        offer(CMD_DELETE,  16'hFFFF, 16'h0000);
        offer(CMD_FIND,    16'hFFFF, 16'h0000);
        offer(CMD_DELETE,  16'h0000, 16'h0000);
        offer(CMD_APPEND,  16'h7777, 16'h0001);
        offer(CMD_FIND,    16'hBEEF, 16'h0000);
        offer(CMD_W'(6),   16'h5555, 16'hAAAA);
        offer(CMD_W'(7),   16'hFFFF, 16'hFFFF);
        offer(CMD_REINIT,  16'h0000, 16'h0000);
        offer(CMD_FIND,    16'h1234, 16'h0000);
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned done;
        int unsigned roll;
        int unsigned n;
        done = 0;
        while (done < target) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                fill_pool(n);
                done += n;
            end else if (roll < 90) begin
                n = $urandom_range(8, 24);
                repeat (n) offer(pick_cmd(), pick_key(), pick_tag());
                done += n;
            end else begin
                // Unknown codes leave the table alone.
                repeat ($urandom_range(1, 4))
                    offer(CMD_W'($urandom_range(6, 7)), ID_W'($urandom), TAG_W'($urandom));
            end
        end
    endtask

    initial begin
        int unsigned n;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = '0;
        i_entry_id    = '0;
        i_handler_tag = '0;
        send_idle_pct = 20;
        recv_idle_pct = 64;
        hold_req      = 1'b0;
        key_base      = ID_W'($urandom);
        registry      = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        fill_pool(n);
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        send_idle_pct = 64;
        recv_idle_pct = 20;
        // The receiver holds off while transfers keep coming, so the input backs up.
        hold_req = 1'b1;
        run_random(ITEMS_PER_PHASE);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(ITEMS_PER_PHASE);
        i_in_valid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (registry.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
